[rtl/core/fdb2_pkg.sv]
package fdb2_pkg;

	// Filter geometry
	localparam int TAP_COUNT = 25;
	localparam int TAP_IDX_W = $clog2(TAP_COUNT);

	// Coefficients are signed Q0.17
	localparam int COEF_BITS = 18;
	localparam int FRAC_BITS = 17;

	typedef logic signed [COEF_BITS-1:0] coef_t;

	// Symmetric impulse response, oldest sample first
	localparam coef_t COEFS [TAP_COUNT] = '{
		18'sd472,    18'sd391,    -18'sd901,   -18'sd2317,  -18'sd1177,
		18'sd2654,   18'sd4283,   -18'sd957,   -18'sd8806,  -18'sd6675,
		18'sd12646,  18'sd38962,  18'sd51339,  18'sd38962,  18'sd12646,
		-18'sd6675,  -18'sd8806,  -18'sd957,   18'sd4283,   18'sd2654,
		-18'sd1177,  -18'sd2317,  -18'sd901,   18'sd391,    18'sd472
	};

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;     // input transaction this cycle
		logic clear_acc;  // start a new sum
		logic issue;      // read one tap into the MAC pipe
		logic load_out;   // move rounded sum into the output register
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic emit;       // the next accepted sample produces an output
		logic last_tap;   // tap counter is at the final tap
		logic pipe_busy;  // MAC pipe still holds products
		logic out_free;   // output register can take a new value
	} dp_status_t;

endpackage

[rtl/core/fdb2_ctrl.sv]
module fdb2_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  fdb2_pkg::dp_status_t  status,
	output fdb2_pkg::ctrl_cmd_t   cmd
);

	fdb2_pkg::state_t state_q;
	fdb2_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdb2_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fdb2_pkg::ST_IDLE: begin
				if (in_valid && status.emit) begin
					state_d = fdb2_pkg::ST_MAC;
				end
			end
			fdb2_pkg::ST_MAC: begin
				if (status.last_tap) begin
					state_d = fdb2_pkg::ST_DRAIN;
				end
			end
			fdb2_pkg::ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = fdb2_pkg::ST_OUT;
				end
			end
			fdb2_pkg::ST_OUT: begin
				if (status.out_free) begin
					state_d = fdb2_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fdb2_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			fdb2_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.accept    = in_valid;
				cmd.clear_acc = in_valid && status.emit;
			end
			fdb2_pkg::ST_MAC: begin
				cmd.issue = 1'b1;
			end
			fdb2_pkg::ST_OUT: begin
				cmd.load_out = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[rtl/core/fdb2_dp.sv]
module fdb2_dp #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fdb2_pkg::ctrl_cmd_t           cmd,
	output fdb2_pkg::dp_status_t          status,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] filtered_sample
);

	localparam int IW    = fdb2_pkg::TAP_IDX_W;
	localparam int PROD_W = SAMPLE_BITS + fdb2_pkg::COEF_BITS;
	// sum of |coef| is below 2^18, plus headroom for the rounding bias
	localparam int ACC_W = SAMPLE_BITS + fdb2_pkg::COEF_BITS + 2;
	localparam int RES_W = ACC_W - fdb2_pkg::FRAC_BITS;
	localparam logic [IW-1:0] LAST_IDX = IW'(fdb2_pkg::TAP_COUNT - 1);
	localparam logic signed [ACC_W-1:0] ROUND_BIAS =
		ACC_W'(1) << (fdb2_pkg::FRAC_BITS - 1);

	// History ring; entries never written since reset read as zero
	logic [SAMPLE_BITS-1:0]        ring_mem [fdb2_pkg::TAP_COUNT];
	logic [fdb2_pkg::TAP_COUNT-1:0] ring_vld_q;
	logic [IW-1:0]                 wr_idx_q;
	logic [IW-1:0]                 wr_idx_nxt;
	logic [IW-1:0]                 rd_idx_q;
	logic [IW-1:0]                 tap_q;
	logic                          phase_q;

	// MAC pipe
	logic                          vld_s1;
	logic [SAMPLE_BITS-1:0]        raw_s1;
	logic                          hit_s1;
	fdb2_pkg::coef_t               coef_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic                          vld_s2;
	logic signed [PROD_W-1:0]      prod_s2;
	logic signed [ACC_W-1:0]       acc_q;

	// Rounding and saturation
	logic signed [ACC_W-1:0]       rnd_sum;
	logic signed [RES_W-1:0]       rnd_res;
	logic                          sat_hi;
	logic                          sat_lo;
	logic signed [SAMPLE_BITS-1:0] sat_res;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_q;

	assign wr_idx_nxt = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + IW'(1);

	// Ring write port
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ring_mem[wr_idx_q] <= sample_in;
		end
	end

	// Ring read port, registered
	always_ff @(posedge clk) begin
		raw_s1  <= ring_mem[rd_idx_q];
		hit_s1  <= ring_vld_q[rd_idx_q];
		coef_s1 <= fdb2_pkg::COEFS[tap_q];
	end

	// Ring control: valid bits, indexes, phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			wr_idx_q   <= '0;
			rd_idx_q   <= '0;
			tap_q      <= '0;
			phase_q    <= 1'b0;
		end else begin
			if (cmd.accept) begin
				ring_vld_q[wr_idx_q] <= 1'b1;
				wr_idx_q             <= wr_idx_nxt;
				phase_q              <= !phase_q;
			end
			if (cmd.clear_acc) begin
				// oldest sample sits at the slot after the newest
				rd_idx_q <= wr_idx_nxt;
				tap_q    <= '0;
			end else if (cmd.issue) begin
				rd_idx_q <= (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + IW'(1);
				tap_q    <= (tap_q == LAST_IDX) ? '0 : tap_q + IW'(1);
			end
		end
	end

	// Pipe valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	assign smp_s1 = hit_s1 ? $signed(raw_s1) : '0;

	// Multiplier stage
	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(smp_s1) * PROD_W'(coef_s1);
	end

	// Accumulator
	always_ff @(posedge clk) begin
		if (cmd.clear_acc) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Round half up, then clamp to the sample range
	assign rnd_sum = acc_q + ROUND_BIAS;
	assign rnd_res = rnd_sum[ACC_W-1:fdb2_pkg::FRAC_BITS];
	assign sat_hi  = !rnd_res[RES_W-1] && (|rnd_res[RES_W-1:SAMPLE_BITS-1]);
	assign sat_lo  = rnd_res[RES_W-1] && !(&rnd_res[RES_W-1:SAMPLE_BITS-1]);

	always_comb begin
		if (sat_hi) begin
			sat_res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else if (sat_lo) begin
			sat_res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			sat_res = rnd_res[SAMPLE_BITS-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= sat_res;
		end
	end

	assign out_valid       = out_valid_q;
	assign filtered_sample = out_q;

	// Status back to the controller
	assign status.emit      = !phase_q;
	assign status.last_tap  = (tap_q == LAST_IDX);
	assign status.pipe_busy = vld_s1 || vld_s2;
	assign status.out_free  = !out_valid_q || out_ready;

endmodule

[rtl/core/fir_decimate_by_two.sv]
// 25-tap symmetric FIR low-pass with decimation by two, signed Q1.15 samples.
//
// Input channel: sample_in with in_valid / in_ready. Output channel:
// filtered_sample with out_valid / out_ready. A transaction completes on a
// clock edge where valid and ready are both high.
//
// Every input sample goes into a 25-entry history ring. The first sample after
// reset and every second one after that produce one output; the others only
// update the history, and the block stays ready for the next input.
// A kept sample runs 25 multiply-accumulates through one shared multiplier
// (ring read, multiply, accumulate stages), then rounds and saturates.
// From accepting a kept sample, the controller passes through MAC, DRAIN and
// OUT before out_valid rises; in_ready returns in the same cycle, so a kept
// sample holds the input until its result is loaded.
// The result sits in an output register, so a stalled receiver does not block
// the next input; the block only waits before loading a new result while the
// previous one is still untaken.
// Reset clears the history to zero, the ring index and the decimation phase.
module fir_decimate_by_two #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] filtered_sample
);

	fdb2_pkg::ctrl_cmd_t  cmd;
	fdb2_pkg::dp_status_t status;

	fdb2_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	fdb2_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.sample_in       (sample_in),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.filtered_sample (filtered_sample)
	);

`ifndef SYNTHESIS
	// no new sample while the MAC pipe still flushes
	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		status.pipe_busy |-> !in_ready)
		else $error("input accepted while MAC pipe busy");

	// the result is loaded only after all products reached the sum
	a_load_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !status.pipe_busy && !cmd.issue)
		else $error("output loaded before accumulation finished");

	// a discarded sample frees the input on the next cycle
	a_discard_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && !status.emit |=> in_ready)
		else $error("discarded sample did not return to idle");
`endif

endmodule
